// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a plain property, disabled while reset is low.
`define CSF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check of an overlapped implication, disabled while reset is low.
`define CSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Concurrent check of a next-cycle implication, disabled while reset is low.
`define CSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/csf_pkg.sv =====
package csf_pkg;

  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  typedef enum logic {
    ReqText  = 1'b0,
    ReqFlush = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    EvByte     = 2'd0,
    EvFieldEnd = 2'd1,
    EvRowEnd   = 2'd2
  } event_kind_e;

  typedef struct packed {
    req_type_e  req_type;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  field_byte;
  } out_item_t;

  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic field_begun;
    logic row_has_fields;
  } split_state_t;

endpackage

// ===== hw/rtl/csv_field_splitter.sv =====
// Channel   Dir  tdata               tuser
// s_axis    in   [7:0] text_byte     [0] req_type (0 text byte, 1 end of input)
// m_axis    out  [7:0] field_byte    [1:0] event_kind (0 byte, 1 field, 2 row)
//
// One transaction per cycle is sustained in both directions while m_axis_tready stays high.
// An input transaction passes through the input register, decision logic and result register.
// Reset clears the quote and field flags and both valid registers.
// A stalled result holds the result register; input stalls only once the
// input register also holds an item that produces a result.
module csv_field_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] text_byte
  input  logic       s_axis_tuser_i,  // [0] req_type
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] field_byte
  output logic [1:0] m_axis_tuser_o   // [1:0] event_kind
);
  import csf_pkg::*;

  in_item_t  s_item, in_item;
  out_item_t res, m_item;
  logic      in_vld, consume, res_vld, out_free;

  assign s_item.req_type  = req_type_e'(s_axis_tuser_i);
  assign s_item.text_byte = s_axis_tdata_i;

  csf_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_vld_i  (s_axis_tvalid_i),
    .s_rdy_o  (s_axis_tready_o),
    .s_item_i (s_item),
    .consume_i(consume),
    .vld_o    (in_vld),
    .item_o   (in_item)
  );

  csf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (in_vld),
    .in_item_i (in_item),
    .out_free_i(out_free),
    .consume_o (consume),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  csf_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_vld),
    .item_i  (res),
    .free_o  (out_free),
    .m_vld_o (m_axis_tvalid_o),
    .m_rdy_i (m_axis_tready_i),
    .m_item_o(m_item)
  );

  assign m_axis_tdata_o = m_item.field_byte;
  assign m_axis_tuser_o = m_item.event_kind;

endmodule

// ===== hw/rtl/csf_in_reg.sv =====
module csf_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_vld_i,
  output logic              s_rdy_o,
  input  csf_pkg::in_item_t s_item_i,
  input  logic              consume_i,
  output logic              vld_o,
  output csf_pkg::in_item_t item_o
);
  import csf_pkg::*;

  logic     vld_q, vld_d;
  in_item_t item_q;
  logic     fire;

  assign s_rdy_o = !vld_q || consume_i;
  assign fire    = s_vld_i && s_rdy_o;

  always_comb begin
    vld_d = vld_q;
    if (fire) begin
      vld_d = 1'b1;
    end else if (consume_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= s_item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== hw/rtl/csf_core.sv =====
`include "assert_macros.svh"

module csf_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  input  csf_pkg::in_item_t  in_item_i,
  input  logic               out_free_i,
  output logic               consume_o,
  output logic               res_vld_o,
  output csf_pkg::out_item_t res_o
);
  import csf_pkg::*;

  split_state_t st_q, st_d;
  logic         emit;
  out_item_t    res;
  logic [7:0]   b;
  logic         plain;

  assign b = in_item_i.text_byte;

  always_comb begin
    st_d             = st_q;
    emit             = 1'b0;
    plain            = 1'b0;
    res.event_kind   = EvByte;
    res.field_byte   = 8'h00;
    if (in_item_i.req_type == ReqFlush) begin
      st_d           = '0;
      emit           = st_q.field_begun || st_q.row_has_fields;
      res.event_kind = EvRowEnd;
    end else if (st_q.quote_pending) begin
      st_d.quote_pending = 1'b0;
      if (b == CharQuote) begin
        emit           = 1'b1;
        res.field_byte = CharQuote;
      end else begin
        st_d.inside_quotes = 1'b0;
        plain              = 1'b1;
      end
    end else if (st_q.inside_quotes) begin
      if (b == CharQuote) begin
        st_d.quote_pending = 1'b1;
      end else begin
        emit           = 1'b1;
        res.field_byte = b;
      end
    end else begin
      plain = 1'b1;
    end

    if (plain) begin
      if (b == CharQuote) begin
        st_d.inside_quotes = 1'b1;
        st_d.field_begun   = 1'b1;
      end else if (b == CharComma) begin
        st_d.field_begun    = 1'b0;
        st_d.row_has_fields = 1'b1;
        emit                = 1'b1;
        res.event_kind      = EvFieldEnd;
      end else if (b == CharLf || b == CharCr) begin
        if (st_q.field_begun || st_q.row_has_fields) begin
          st_d.field_begun    = 1'b0;
          st_d.row_has_fields = 1'b0;
          emit                = 1'b1;
          res.event_kind      = EvRowEnd;
        end
      end else begin
        st_d.field_begun = 1'b1;
        emit             = 1'b1;
        res.field_byte   = b;
      end
    end
  end

  assign consume_o = in_vld_i && (!emit || out_free_i);
  assign res_vld_o = in_vld_i && emit && out_free_i;
  assign res_o     = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (consume_o) begin
      st_q <= st_d;
    end
  end

  `CSF_ASSERT_IMP(a_pending_in_quotes, clk_i, rst_ni, st_q.quote_pending, st_q.inside_quotes, "quote pending outside quotes")
  `CSF_ASSERT_NXT(a_flush_clears, clk_i, rst_ni, consume_o && in_item_i.req_type == ReqFlush, st_q == '0, "state not cleared after end of input")
  `CSF_ASSERT_IMP(a_end_no_byte, clk_i, rst_ni, res_vld_o && res_o.event_kind != EvByte, res_o.field_byte == 8'h00, "nonzero byte on field or row end")

endmodule

// ===== hw/rtl/csf_out_reg.sv =====
module csf_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  csf_pkg::out_item_t item_i,
  output logic               free_o,
  output logic               m_vld_o,
  input  logic               m_rdy_i,
  output csf_pkg::out_item_t m_item_o
);
  import csf_pkg::*;

  logic      vld_q, vld_d;
  out_item_t item_q;

  assign free_o = !vld_q || m_rdy_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (m_rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign m_vld_o  = vld_q;
  assign m_item_o = item_q;

endmodule

// ===== verif/tb_csv_field_splitter.sv =====
`timescale 1ns / 100ps

module tb_csv_field_splitter;
  import csf_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tuser = ReqText;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b1;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  out_item_t  pending_events[$];
  int         error_count = 0;
  int         bytes_sent = 0;
  bit         src_gaps_on = 1'b1;
  bit         sink_stalls_on = 1'b1;
  int         ready_hold = 0;
  int         ready_roll;

  logic       in_quotes = 1'b0;
  logic       quote_held = 1'b0;
  logic       field_open = 1'b0;
  logic       row_open = 1'b0;

  csv_field_splitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void push_event(event_kind_e kind, logic [7:0] b);
    out_item_t ev;
    ev.event_kind = kind;
    ev.field_byte = b;
    pending_events.push_back(ev);
  endfunction

  function automatic void split_unquoted(logic [7:0] b);
    if (b == CharQuote) begin
      in_quotes  = 1'b1;
      field_open = 1'b1;
    end else if (b == CharComma) begin
      field_open = 1'b0;
      row_open   = 1'b1;
      push_event(EvFieldEnd, 8'h00);
    end else if (b == CharLf || b == CharCr) begin
      if (field_open || row_open) begin
        field_open = 1'b0;
        row_open   = 1'b0;
        push_event(EvRowEnd, 8'h00);
      end
    end else begin
      field_open = 1'b1;
      push_event(EvByte, b);
    end
  endfunction

  function automatic void split_transaction(req_type_e req, logic [7:0] b);
    if (req == ReqFlush) begin
      if (field_open || row_open) push_event(EvRowEnd, 8'h00);
      in_quotes  = 1'b0;
      quote_held = 1'b0;
      field_open = 1'b0;
      row_open   = 1'b0;
    end else if (quote_held) begin
      quote_held = 1'b0;
      if (b == CharQuote) begin
        push_event(EvByte, CharQuote);
      end else begin
        in_quotes = 1'b0;
        split_unquoted(b);
      end
    end else if (in_quotes) begin
      if (b == CharQuote) quote_held = 1'b1;
      else push_event(EvByte, b);
    end else begin
      split_unquoted(b);
    end
  endfunction

  // Check the result side first, then predict from the input side.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d byte %02h",
                 $time, m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser !== want.event_kind) begin
          $display("%0t: event_kind expected %0d actual %0d",
                   $time, want.event_kind, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata !== want.field_byte) begin
          $display("%0t: field_byte expected %02h actual %02h",
                   $time, want.field_byte, m_axis_tdata);
          error_count++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      split_transaction(req_type_e'(s_axis_tuser), s_axis_tdata);
  end

  always @(negedge clk_i) begin
    if (!sink_stalls_on) begin
      m_axis_tready = 1'b1;
      ready_hold    = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        m_axis_tready = 1'b1;
        ready_hold    = $urandom_range(0, 4);
      end else if (ready_roll < 93) begin
        m_axis_tready = 1'b0;
        ready_hold    = $urandom_range(0, 2);
      end else begin
        m_axis_tready = 1'b0;
        ready_hold    = $urandom_range(8, 30);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!src_gaps_on || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(req_type_e req, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = pick_any_byte();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_text(logic [7:0] b);
    send_item(ReqText, b);
  endtask

  function automatic logic [7:0] pick_plain_byte();
    logic [7:0] b;
    do b = pick_any_byte();
    while (b inside {CharQuote, CharComma, CharLf, CharCr});
    return b;
  endfunction

  task automatic send_quoted_field(bit closed);
    int n;
    int roll;
    send_text(CharQuote);
    n = $urandom_range(0, 6);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_text(CharQuote);
        send_text(CharQuote);
      end else if (roll < 20) send_text(CharComma);
      else if (roll < 25) send_text(CharCr);
      else if (roll < 30) send_text(CharLf);
      else send_text(pick_plain_byte());
    end
    if (closed) send_text(CharQuote);
  endtask

  task automatic send_row_break();
    case ($urandom_range(0, 2))
      0: send_text(CharCr);
      1: send_text(CharLf);
      default: begin
        send_text(CharCr);
        send_text(CharLf);
      end
    endcase
  endtask

  // Well-formed rows with random content; a few rows are left open or broken.
  task automatic send_csv_stream(int budget);
    int stop_at;
    int fields;
    int roll;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_row_break();
      fields = $urandom_range(1, 5);
      for (int f = 0; f < fields; f++) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
        end else if (roll < 60) begin
          repeat ($urandom_range(1, 6)) send_text(pick_plain_byte());
        end else if (roll < 92) begin
          send_quoted_field(1'b1);
        end else begin
          send_text(pick_plain_byte());
          send_quoted_field(1'($urandom_range(0, 1)));
        end
        if (f < fields - 1) send_text(CharComma);
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) send_row_break();
      else if (roll < 90) send_item(ReqFlush, pick_any_byte());
      else begin
        send_quoted_field(1'b0);
        send_item(ReqFlush, pick_any_byte());
      end
    end
    send_item(ReqFlush, pick_any_byte());
  endtask

  task automatic test_directed();
    send_item(ReqFlush, 8'hFF);
    send_text(CharLf);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(CharComma);
    send_text(CharQuote);
    send_text(CharComma);
    send_text(CharQuote);
    send_text(CharQuote);
    send_text(CharLf);
    send_text(CharQuote);
    send_text("a");
    send_text(CharCr);
    send_text(CharLf);
    send_text("x");
    send_text(CharQuote);
    send_text(CharQuote);
    send_item(ReqFlush, 8'h00);
    send_text(CharQuote);
    send_text(8'hC3);
    send_item(ReqFlush, 8'h55);
    send_text(CharComma);
    send_text(CharCr);
  endtask

  task automatic test_back_to_back();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_csv_stream(100);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic test_random_rows();
    send_csv_stream(280);
  endtask

  task automatic test_full_backpressure();
    src_gaps_on = 1'b0;
    send_csv_stream(60);
    src_gaps_on = 1'b1;
  endtask

  task automatic test_noise();
    int roll;
    repeat (120) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) send_item(ReqFlush, pick_any_byte());
      else if (roll < 15) send_text(CharQuote);
      else if (roll < 22) send_text(CharComma);
      else if (roll < 28) send_text(CharCr);
      else if (roll < 34) send_text(CharLf);
      else send_text(pick_any_byte());
    end
    send_item(ReqFlush, pick_any_byte());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_back_to_back();
    test_random_rows();
    test_full_backpressure();
    test_noise();

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (pending_events.size() == 0);
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/csf_pkg.sv
hw/rtl/csf_in_reg.sv
hw/rtl/csf_core.sv
hw/rtl/csf_out_reg.sv
hw/rtl/csv_field_splitter.sv
verif/tb_csv_field_splitter.sv
